/* hw/rtl/ncctm_pkg.sv */
// Shared types and constants for the normalized cross-correlation template matcher.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ncctm_pkg;
    localparam int SRC_DIM      = 64;
    localparam int TPL_DIM      = 16;
    localparam int PIX_W        = 8;
    localparam int SRC_DIM_W    = 7;
    localparam int TPL_DIM_W    = 5;
    localparam int POS_W        = 6;
    localparam int SRC_DEPTH    = SRC_DIM * SRC_DIM;
    localparam int TPL_DEPTH    = TPL_DIM * TPL_DIM;
    localparam int SRC_ADDR_W   = $clog2(SRC_DEPTH);
    localparam int TPL_ADDR_W   = $clog2(TPL_DEPTH);
    localparam int SRC_CNT_W    = SRC_ADDR_W + 1;
    localparam int TPL_CNT_W    = TPL_ADDR_W + 1;
    localparam int TPL_IDX_W    = $clog2(TPL_DIM);
    localparam int ACC_W        = 24;
    localparam int SCORE_W      = 17;
    localparam int MUL_A_W      = 48;
    localparam int MUL_B_W      = 34;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TPL_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TPL_WIDTH  = 2'd3;

    localparam logic [SCORE_W-1:0] SCORE_ONE = 17'd65536;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] pixel;
    } t_item;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   best_row;
        logic [POS_W-1:0]   best_col;
        logic [SCORE_W-1:0] score;
    } t_result;

    typedef struct packed {
        logic [SRC_DIM_W-1:0] src_h;
        logic [SRC_DIM_W-1:0] src_w;
        logic [TPL_DIM_W-1:0] tpl_h;
        logic [TPL_DIM_W-1:0] tpl_w;
    } t_dims;

    typedef struct packed {
        logic                  src_we;
        logic                  tpl_we;
        logic [SRC_ADDR_W-1:0] src_addr;
        logic [TPL_ADDR_W-1:0] tpl_addr;
        logic [PIX_W-1:0]      pixel;
    } t_wr;

    typedef struct packed {
        logic [SRC_ADDR_W-1:0] src_addr;
        logic [TPL_ADDR_W-1:0] tpl_addr;
    } t_rd;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;
endpackage
`default_nettype wire

/* hw/rtl/ncc_template_match_core.sv */
// Top level of the template matcher: configuration registers, pixel loading, search core.
// Instantiates ncctm_store, ncctm_mul and ncctm_seq; depends on ncctm_pkg.
// Loading takes one word per cycle while the block is not busy. The search visits every offset,
// compares each offset with a nonzero window energy against a previous best, and then rounds
// the score; the shared multiplier does the compares and the rounding.
// Synchronous reset clears the counts and loads sizes 64x64 and 8x8; pixel memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module ncc_template_match_core
    import ncctm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_item                 i_item,
    output logic                       o_result_valid,
    output t_result                    o_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [SRC_DIM_W-1:0] r_src_h;
    logic [SRC_DIM_W-1:0] r_src_w;
    logic [TPL_DIM_W-1:0] r_tpl_h;
    logic [TPL_DIM_W-1:0] r_tpl_w;
    logic [SRC_CNT_W-1:0] r_src_cnt;
    logic [TPL_CNT_W-1:0] r_tpl_cnt;
    logic                 r_go;
    logic [SRC_CNT_W-1:0] n_src_cnt;
    logic [TPL_CNT_W-1:0] n_tpl_cnt;
    logic [SRC_CNT_W-1:0] src_total;
    logic [TPL_CNT_W-1:0] tpl_total;
    logic                 accept;
    logic                 trigger;
    logic                 seq_busy;
    t_dims                dims;
    t_wr                  wr;
    t_rd                  rd;
    t_mul_req             mul_req;
    logic                 mul_done;
    logic [PROD_W-1:0]    mul_prod;
    logic [PIX_W-1:0]     src_data;
    logic [PIX_W-1:0]     tpl_data;
    logic [SRC_DIM_W-1:0] src_clamped;
    logic [TPL_DIM_W-1:0] tpl_clamped;

    assign busy        = r_go | seq_busy;
    assign o_cfg_ready = ~busy;
    assign accept      = start & ~busy;
    assign src_total   = SRC_CNT_W'(r_src_h) * SRC_CNT_W'(r_src_w);
    assign tpl_total   = TPL_CNT_W'(r_tpl_h) * TPL_CNT_W'(r_tpl_w);
    assign dims        = '{src_h: r_src_h, src_w: r_src_w, tpl_h: r_tpl_h, tpl_w: r_tpl_w};

    always_comb begin
        if (i_cfg_data == '0) begin
            src_clamped = SRC_DIM_W'(1);
        end else if (i_cfg_data > SRC_DIM_W'(SRC_DIM)) begin
            src_clamped = SRC_DIM_W'(SRC_DIM);
        end else begin
            src_clamped = i_cfg_data;
        end
        if (i_cfg_data[TPL_DIM_W-1:0] == '0) begin
            tpl_clamped = TPL_DIM_W'(1);
        end else if (i_cfg_data[TPL_DIM_W-1:0] > TPL_DIM_W'(TPL_DIM)) begin
            tpl_clamped = TPL_DIM_W'(TPL_DIM);
        end else begin
            tpl_clamped = i_cfg_data[TPL_DIM_W-1:0];
        end
    end

    always_comb begin
        n_src_cnt   = r_src_cnt;
        n_tpl_cnt   = r_tpl_cnt;
        wr.src_we   = 1'b0;
        wr.tpl_we   = 1'b0;
        wr.src_addr = r_src_cnt[SRC_ADDR_W-1:0];
        wr.tpl_addr = r_tpl_cnt[TPL_ADDR_W-1:0];
        wr.pixel    = i_item.pixel;
        if (accept) begin
            if (i_item.mode) begin
                if (r_src_cnt < src_total) begin
                    wr.src_we = 1'b1;
                    n_src_cnt = r_src_cnt + 1'b1;
                end
            end else if (r_tpl_cnt < tpl_total) begin
                wr.tpl_we = 1'b1;
                n_tpl_cnt = r_tpl_cnt + 1'b1;
            end
        end
        trigger = accept && (n_src_cnt >= src_total) && (n_tpl_cnt >= tpl_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_h   <= SRC_DIM_W'(64);
            r_src_w   <= SRC_DIM_W'(64);
            r_tpl_h   <= TPL_DIM_W'(8);
            r_tpl_w   <= TPL_DIM_W'(8);
            r_src_cnt <= '0;
            r_tpl_cnt <= '0;
            r_go      <= 1'b0;
        end else begin
            r_go <= trigger;
            if (trigger) begin
                r_src_cnt <= '0;
                r_tpl_cnt <= '0;
            end else begin
                r_src_cnt <= n_src_cnt;
                r_tpl_cnt <= n_tpl_cnt;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SRC_HEIGHT: r_src_h <= src_clamped;
                    CFG_SRC_WIDTH:  r_src_w <= src_clamped;
                    CFG_TPL_HEIGHT: r_tpl_h <= tpl_clamped;
                    CFG_TPL_WIDTH:  r_tpl_w <= tpl_clamped;
                    default: begin
                    end
                endcase
            end
        end
    end

    ncctm_store u_store (
        .i_clk      (i_clk),
        .i_wr       (wr),
        .i_rd       (rd),
        .o_src_data (src_data),
        .o_tpl_data (tpl_data)
    );

    ncctm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    ncctm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (r_go),
        .i_dims     (dims),
        .o_rd       (rd),
        .i_src_data (src_data),
        .i_tpl_data (tpl_data),
        .o_mul      (mul_req),
        .i_mul_done (mul_done),
        .i_mul_prod (mul_prod),
        .o_busy     (seq_busy),
        .o_valid    (o_result_valid),
        .o_result   (o_result)
    );
endmodule
`default_nettype wire

/* hw/rtl/ncctm_store.sv */
// Source and template pixel memories, one write and one registered read port each.
// Depends on ncctm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ncctm_store
    import ncctm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_wr              i_wr,
    input  wire t_rd              i_rd,
    output logic [PIX_W-1:0]      o_src_data,
    output logic [PIX_W-1:0]      o_tpl_data
);
    logic [PIX_W-1:0] r_src_mem [SRC_DEPTH];
    logic [PIX_W-1:0] r_tpl_mem [TPL_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.src_we) begin
            r_src_mem[i_wr.src_addr] <= i_wr.pixel;
        end
        o_src_data <= r_src_mem[i_rd.src_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.tpl_we) begin
            r_tpl_mem[i_wr.tpl_addr] <= i_wr.pixel;
        end
        o_tpl_data <= r_tpl_mem[i_rd.tpl_addr];
    end
endmodule
`default_nettype wire

/* hw/rtl/ncctm_mul.sv */
// Shared shift-add multiplier, one multiplier bit per cycle.
// Depends on ncctm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ncctm_mul
    import ncctm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_mul_req    i_req,
    output logic             o_done,
    output logic [PROD_W-1:0] o_prod
);
    localparam int CNT_W = $clog2(MUL_B_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_B_W - 1);

    logic               r_run;
    logic [CNT_W-1:0]   r_cnt;
    logic [PROD_W-1:0]  r_ma;
    logic [MUL_B_W-1:0] r_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_run  <= 1'b1;
                r_cnt  <= '0;
                o_prod <= '0;
                r_ma   <= PROD_W'(i_req.a);
                r_mb   <= i_req.b;
            end else if (r_run) begin
                if (r_mb[0]) begin
                    o_prod <= o_prod + r_ma;
                end
                r_ma  <= r_ma << 1;
                r_mb  <= r_mb >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/ncctm_seq.sv */
// Search sequencer: energy and window sums, best-score tracking and score rounding.
// Drives the shared multiplier; depends on ncctm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ncctm_seq
    import ncctm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_go,
    input  wire t_dims             i_dims,
    output t_rd                    o_rd,
    input  wire logic [PIX_W-1:0]  i_src_data,
    input  wire logic [PIX_W-1:0]  i_tpl_data,
    output t_mul_req               o_mul,
    input  wire logic              i_mul_done,
    input  wire logic [PROD_W-1:0] i_mul_prod,
    output logic                   o_busy,
    output logic                   o_valid,
    output t_result                o_result
);
    typedef enum logic [3:0] {
        S_IDLE, S_TE, S_TE_DRAIN, S_TE_CHECK, S_WIN, S_WIN_DRAIN, S_EVAL,
        S_MUL, S_NEXT, S_SCORE, S_BS, S_RESULT
    } t_state;

    typedef enum logic [2:0] {
        OP_CC, OP_X, OP_BB, OP_Y, OP_P, OP_RC, OP_D2, OP_LHS
    } t_op;

    t_state                r_state;
    t_op                   r_op;
    logic                  r_dv;
    logic                  r_dv_te;
    logic [TPL_CNT_W-1:0]  r_k;
    logic [TPL_IDX_W-1:0]  r_i;
    logic [TPL_IDX_W-1:0]  r_j;
    logic [POS_W-1:0]      r_r;
    logic [POS_W-1:0]      r_c;
    logic [SRC_ADDR_W-1:0] r_rbase;
    logic [SRC_ADDR_W-1:0] r_row_base;
    logic [TPL_ADDR_W-1:0] r_tpl_base;
    logic [ACC_W-1:0]      r_te;
    logic [ACC_W-1:0]      r_corr;
    logic [ACC_W-1:0]      r_ew;
    logic                  r_have;
    logic [ACC_W-1:0]      r_bcorr;
    logic [ACC_W-1:0]      r_bew;
    logic [POS_W-1:0]      r_brow;
    logic [POS_W-1:0]      r_bcol;
    logic [PROD_W-1:0]     r_x;
    logic [MUL_A_W-1:0]    r_p;
    logic [PROD_W-1:0]     r_rhs;
    logic [SCORE_W-1:0]    r_lo;
    logic [SCORE_W-1:0]    r_hi;
    logic [SCORE_W-1:0]    r_mid;

    logic [TPL_CNT_W-1:0]  tpl_total;
    logic                  j_last;
    logic                  i_last;
    logic [SCORE_W:0]      mid_sum;
    logic [SCORE_W-1:0]    mid;
    logic [SCORE_W:0]      dval;

    assign tpl_total = TPL_CNT_W'(i_dims.tpl_h) * TPL_CNT_W'(i_dims.tpl_w);
    assign j_last    = ({1'b0, r_j} == i_dims.tpl_w - 1'b1);
    assign i_last    = ({1'b0, r_i} == i_dims.tpl_h - 1'b1);
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi} + 1'b1;
    assign mid       = mid_sum[SCORE_W:1];
    assign dval      = {mid, 1'b0} - 1'b1;
    assign o_busy    = (r_state != S_IDLE);

    always_comb begin
        o_rd.src_addr = SRC_ADDR_W'(r_row_base + SRC_ADDR_W'(r_c) + SRC_ADDR_W'(r_j));
        if (r_state == S_TE) begin
            o_rd.tpl_addr = r_k[TPL_ADDR_W-1:0];
        end else begin
            o_rd.tpl_addr = TPL_ADDR_W'(r_tpl_base + TPL_ADDR_W'(r_j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_CC;
            r_dv        <= 1'b0;
            r_dv_te     <= 1'b0;
            o_valid     <= 1'b0;
            o_mul.start <= 1'b0;
            r_have      <= 1'b0;
        end else begin
            o_valid     <= 1'b0;
            o_mul.start <= 1'b0;
            r_dv        <= 1'b0;
            if (r_dv) begin
                if (r_dv_te) begin
                    r_te <= r_te + ACC_W'(i_tpl_data) * ACC_W'(i_tpl_data);
                end else begin
                    r_corr <= r_corr + ACC_W'(i_src_data) * ACC_W'(i_tpl_data);
                    r_ew   <= r_ew + ACC_W'(i_src_data) * ACC_W'(i_src_data);
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_have  <= 1'b0;
                        r_te    <= '0;
                        r_k     <= '0;
                        r_r     <= '0;
                        r_c     <= '0;
                        r_rbase <= '0;
                        o_result <= '0;
                        if (i_dims.tpl_h > TPL_DIM_W'(i_dims.src_h) && i_dims.src_h < 7'd16
                            || i_dims.tpl_w > TPL_DIM_W'(i_dims.src_w) && i_dims.src_w < 7'd16) begin
                            r_state <= S_RESULT;
                        end else begin
                            r_state <= S_TE;
                        end
                    end
                end
                S_TE: begin
                    r_dv    <= 1'b1;
                    r_dv_te <= 1'b1;
                    r_k     <= r_k + 1'b1;
                    if (r_k == tpl_total - 1'b1) begin
                        r_state <= S_TE_DRAIN;
                    end
                end
                S_TE_DRAIN: begin
                    r_state <= S_TE_CHECK;
                end
                S_TE_CHECK: begin
                    r_dv_te    <= 1'b0;
                    r_i        <= '0;
                    r_j        <= '0;
                    r_row_base <= '0;
                    r_tpl_base <= '0;
                    r_corr     <= '0;
                    r_ew       <= '0;
                    r_state    <= (r_te == '0) ? S_RESULT : S_WIN;
                end
                S_WIN: begin
                    r_dv <= 1'b1;
                    if (j_last) begin
                        r_j        <= '0;
                        r_i        <= r_i + 1'b1;
                        r_row_base <= SRC_ADDR_W'(r_row_base + SRC_ADDR_W'(i_dims.src_w));
                        r_tpl_base <= TPL_ADDR_W'(r_tpl_base + TPL_ADDR_W'(i_dims.tpl_w));
                        if (i_last) begin
                            r_state <= S_WIN_DRAIN;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_WIN_DRAIN: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_ew == '0) begin
                        r_state <= S_NEXT;
                    end else if (!r_have) begin
                        r_have  <= 1'b1;
                        r_bcorr <= r_corr;
                        r_bew   <= r_ew;
                        r_brow  <= r_r;
                        r_bcol  <= r_c;
                        r_state <= S_NEXT;
                    end else begin
                        o_mul.start <= 1'b1;
                        o_mul.a     <= MUL_A_W'(r_corr);
                        o_mul.b     <= MUL_B_W'(r_corr);
                        r_op        <= OP_CC;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (i_mul_done) begin
                        case (r_op)
                            OP_CC: begin
                                o_mul.start <= 1'b1;
                                o_mul.a     <= i_mul_prod[MUL_A_W-1:0];
                                o_mul.b     <= MUL_B_W'(r_bew);
                                r_op        <= OP_X;
                            end
                            OP_X: begin
                                r_x         <= i_mul_prod;
                                o_mul.start <= 1'b1;
                                o_mul.a     <= MUL_A_W'(r_bcorr);
                                o_mul.b     <= MUL_B_W'(r_bcorr);
                                r_op        <= OP_BB;
                            end
                            OP_BB: begin
                                o_mul.start <= 1'b1;
                                o_mul.a     <= i_mul_prod[MUL_A_W-1:0];
                                o_mul.b     <= MUL_B_W'(r_ew);
                                r_op        <= OP_Y;
                            end
                            OP_Y: begin
                                if (r_x > i_mul_prod) begin
                                    r_bcorr <= r_corr;
                                    r_bew   <= r_ew;
                                    r_brow  <= r_r;
                                    r_bcol  <= r_c;
                                end
                                r_state <= S_NEXT;
                            end
                            OP_P: begin
                                r_p         <= i_mul_prod[MUL_A_W-1:0];
                                o_mul.start <= 1'b1;
                                o_mul.a     <= MUL_A_W'(r_bcorr);
                                o_mul.b     <= MUL_B_W'(r_bcorr);
                                r_op        <= OP_RC;
                            end
                            OP_RC: begin
                                r_rhs   <= {i_mul_prod[MUL_A_W-1:0], {MUL_B_W{1'b0}}};
                                r_lo    <= '0;
                                r_hi    <= SCORE_ONE;
                                r_state <= S_BS;
                            end
                            OP_D2: begin
                                o_mul.start <= 1'b1;
                                o_mul.a     <= r_p;
                                o_mul.b     <= i_mul_prod[MUL_B_W-1:0];
                                r_op        <= OP_LHS;
                            end
                            OP_LHS: begin
                                if (i_mul_prod <= r_rhs) begin
                                    r_lo <= r_mid;
                                end else begin
                                    r_hi <= r_mid - 1'b1;
                                end
                                r_state <= S_BS;
                            end
                            default: begin
                                r_state <= S_NEXT;
                            end
                        endcase
                    end
                end
                S_NEXT: begin
                    r_i        <= '0;
                    r_j        <= '0;
                    r_tpl_base <= '0;
                    r_corr     <= '0;
                    r_ew       <= '0;
                    if ({1'b0, r_c} == i_dims.src_w - SRC_DIM_W'(i_dims.tpl_w)) begin
                        r_c <= '0;
                        if ({1'b0, r_r} == i_dims.src_h - SRC_DIM_W'(i_dims.tpl_h)) begin
                            r_state <= S_SCORE;
                        end else begin
                            r_r        <= r_r + 1'b1;
                            r_rbase    <= SRC_ADDR_W'(r_rbase + SRC_ADDR_W'(i_dims.src_w));
                            r_row_base <= SRC_ADDR_W'(r_rbase + SRC_ADDR_W'(i_dims.src_w));
                            r_state    <= S_WIN;
                        end
                    end else begin
                        r_c        <= r_c + 1'b1;
                        r_row_base <= r_rbase;
                        r_state    <= S_WIN;
                    end
                end
                S_SCORE: begin
                    if (!r_have) begin
                        r_state <= S_RESULT;
                    end else begin
                        o_mul.start <= 1'b1;
                        o_mul.a     <= MUL_A_W'(r_bew);
                        o_mul.b     <= MUL_B_W'(r_te);
                        r_op        <= OP_P;
                        r_state     <= S_MUL;
                    end
                end
                S_BS: begin
                    if (r_lo < r_hi) begin
                        r_mid       <= mid;
                        o_mul.start <= 1'b1;
                        o_mul.a     <= MUL_A_W'(dval);
                        o_mul.b     <= MUL_B_W'(dval);
                        r_op        <= OP_D2;
                        r_state     <= S_MUL;
                    end else begin
                        o_result.found    <= 1'b1;
                        o_result.best_row <= r_brow;
                        o_result.best_col <= r_bcol;
                        o_result.score    <= r_lo;
                        r_state           <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/ncctm_checker.sv */
// Port-level checks of the template matcher and the bind that attaches them.
// Depends on ncctm_pkg and ncc_template_match_core.
`timescale 1ns / 1ps
`default_nettype none
module ncctm_checker
    import ncctm_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    busy,
    input wire logic    o_result_valid,
    input wire t_result o_result
);
    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe lasted more than one cycle");

    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !busy)
        else $error("block still busy after result");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.found) |->
        (o_result.best_row == '0 && o_result.best_col == '0 && o_result.score == '0))
        else $error("fields not zero when no match was found");

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.score <= SCORE_ONE))
        else $error("score above one");
endmodule

bind ncc_template_match_core ncctm_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
`default_nettype wire

/* tb/sv/tb_ncc_template_match_core_checker.sv */
// Checker for the template matcher: watches the pixel, result and register-write channels.
// Predicts every search result from its own copy of the images and sizes; depends on ncctm_pkg.
`timescale 1ns / 1ps
module tb_ncc_template_match_core_checker
    import ncctm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_busy,
    input  wire t_item                 i_item,
    input  wire logic                  i_result_valid,
    input  wire t_result               i_result,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_pending,
    output int                         o_fail_count
);
    logic [PIX_W-1:0] src_pix [SRC_DEPTH];
    logic [PIX_W-1:0] tpl_pix [TPL_DEPTH];
    int unsigned      src_fill, tpl_fill;
    int unsigned      src_h, src_w, tpl_h, tpl_w;
    t_result          match_q [$];

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned max);
        if (v < 1) return 1;
        if (v > max) return max;
        return v;
    endfunction

    function automatic t_result best_match();
        t_result           r;
        longint unsigned   tpl_energy, corr, win_energy, best_corr, best_energy, s, t, d;
        int unsigned       best_r, best_c, lo, hi, mid;
        bit                have;
        logic [127:0]      lhs, rhs, prod;
        r = '0;
        have = 0;
        best_corr = 0;
        best_energy = 0;
        best_r = 0;
        best_c = 0;
        tpl_energy = 0;
        if (tpl_h > src_h || tpl_w > src_w) return r;
        for (int k = 0; k < tpl_h * tpl_w; k++) begin
            t = tpl_pix[k];
            tpl_energy += t * t;
        end
        if (tpl_energy == 0) return r;
        for (int unsigned row = 0; row + tpl_h <= src_h; row++) begin
            for (int unsigned col = 0; col + tpl_w <= src_w; col++) begin
                corr = 0;
                win_energy = 0;
                for (int unsigned i = 0; i < tpl_h; i++) begin
                    for (int unsigned j = 0; j < tpl_w; j++) begin
                        s = src_pix[(row + i) * src_w + col + j];
                        t = tpl_pix[i * tpl_w + j];
                        corr += s * t;
                        win_energy += s * s;
                    end
                end
                if (win_energy != 0) begin
                    lhs = 128'(corr) * 128'(corr) * 128'(best_energy);
                    rhs = 128'(best_corr) * 128'(best_corr) * 128'(win_energy);
                    if (!have || lhs > rhs) begin
                        have = 1;
                        best_corr = corr;
                        best_energy = win_energy;
                        best_r = row;
                        best_c = col;
                    end
                end
            end
        end
        if (!have) return r;
        prod = 128'(best_energy) * 128'(tpl_energy);
        rhs = (128'(best_corr) * 128'(best_corr)) << 34;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            d = 2 * longint'(mid) - 1;
            lhs = 128'(d * d) * prod;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        r.found = 1'b1;
        r.best_row = best_r[POS_W-1:0];
        r.best_col = best_c[POS_W-1:0];
        r.score = lo[SCORE_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            src_fill = 0;
            tpl_fill = 0;
            src_h = SRC_DIM;
            src_w = SRC_DIM;
            tpl_h = 8;
            tpl_w = 8;
            match_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SRC_HEIGHT: src_h = clamp_dim(i_cfg_data, SRC_DIM);
                    CFG_SRC_WIDTH:  src_w = clamp_dim(i_cfg_data, SRC_DIM);
                    CFG_TPL_HEIGHT: tpl_h = clamp_dim(i_cfg_data & 7'h1f, TPL_DIM);
                    CFG_TPL_WIDTH:  tpl_w = clamp_dim(i_cfg_data & 7'h1f, TPL_DIM);
                    default: ;
                endcase
            end
            if (i_result_valid) begin
                if (match_q.size() == 0) begin
                    $error("result word with no search pending");
                    o_fail_count++;
                end else begin
                    want = match_q.pop_front();
                    if (want != i_result) begin
                        o_fail_count++;
                        if (want.found != i_result.found)
                            $error("found: expected %0d, got %0d", want.found, i_result.found);
                        if (want.best_row != i_result.best_row)
                            $error("best_row: expected %0d, got %0d",
                                   want.best_row, i_result.best_row);
                        if (want.best_col != i_result.best_col)
                            $error("best_col: expected %0d, got %0d",
                                   want.best_col, i_result.best_col);
                        if (want.score != i_result.score)
                            $error("score: expected %0d, got %0d", want.score, i_result.score);
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_item.mode) begin
                    if (src_fill < src_h * src_w) src_pix[src_fill++] = i_item.pixel;
                end else begin
                    if (tpl_fill < tpl_h * tpl_w) tpl_pix[tpl_fill++] = i_item.pixel;
                end
                if (src_fill >= src_h * src_w && tpl_fill >= tpl_h * tpl_w) begin
                    match_q.push_back(best_match());
                    src_fill = 0;
                    tpl_fill = 0;
                end
            end
        end
        o_pending <= match_q.size();
    end
endmodule

/* tb/sv/tb_ncc_template_match_core.sv */
// Testbench top for the template matcher: clock, reset, pixel and register-write stimulus.
// Instantiates ncc_template_match_core and its checker; depends on ncctm_pkg.
`timescale 1ns / 1ps
module tb_ncc_template_match_core;
    import ncctm_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_item                 i_item = '0;
    logic                  o_result_valid;
    t_result               o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    pending, fail_count;
    int                    pixels_sent;
    bit                    no_gaps;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ncc_template_match_core i_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_result_valid, .o_result,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    tb_ncc_template_match_core_checker i_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_item,
        .i_result_valid(o_result_valid), .i_result(o_result),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_pending(pending), .o_fail_count(fail_count)
    );

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
    endtask

    // Encodes a size as is or, at random, as an out-of-range value that the block must clamp or mask to the same size.
    function automatic logic [CFG_DATA_W-1:0] encode_dim(int unsigned dim, bit is_tpl);
        if ($urandom_range(0, 2) != 0) return 7'(dim);
        if (dim == 1 && !is_tpl) return '0;
        if (dim == 1) return 7'(32 * $urandom_range(0, 3));
        if (is_tpl && dim == TPL_DIM) return 7'($urandom_range(16, 31) + 32 * $urandom_range(0, 3));
        if (is_tpl) return 7'(dim + 32 * $urandom_range(0, 3));
        if (dim == SRC_DIM) return 7'($urandom_range(64, 127));
        return 7'(dim);
    endfunction

    task automatic send_pixel(logic mode, logic [PIX_W-1:0] px);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= '{mode: mode, pixel: px};
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    // kind: 0 random, 1 zero source, 2 zero template, 3 only 0 and 255, 4 mostly zeros
    task automatic run_frame(int unsigned sh, int unsigned sw, int unsigned th, int unsigned tw,
                             int kind);
        int unsigned      src_total, tpl_total, src_n, tpl_n;
        logic             mode;
        logic [PIX_W-1:0] px;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        write_reg(CFG_SRC_HEIGHT, encode_dim(sh, 0));
        write_reg(CFG_SRC_WIDTH, encode_dim(sw, 0));
        write_reg(CFG_TPL_HEIGHT, encode_dim(th, 1));
        write_reg(CFG_TPL_WIDTH, encode_dim(tw, 1));
        i_cfg_valid <= 1'b0;
        no_gaps = ($urandom_range(0, 3) == 0);
        src_total = sh * sw;
        tpl_total = th * tw;
        src_n = 0;
        tpl_n = 0;
        while (src_n < src_total || tpl_n < tpl_total) begin
            mode = $urandom_range(0, 1);
            if (src_n >= src_total && $urandom_range(0, 9) != 0) mode = 1'b0;
            if (tpl_n >= tpl_total && $urandom_range(0, 9) != 0) mode = 1'b1;
            case (kind)
                1: px = mode ? 8'd0 : 8'($urandom_range(0, 255));
                2: px = mode ? 8'($urandom_range(0, 255)) : 8'd0;
                3: px = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                4: px = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
                default: px = $urandom_range(0, 255);
            endcase
            send_pixel(mode, px);
            if (mode && src_n < src_total) begin
                src_n++;
                pixels_sent++;
            end else if (!mode && tpl_n < tpl_total) begin
                tpl_n++;
                pixels_sent++;
            end
        end
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int frame;
        int unsigned sh, sw, th, tw;
        pixels_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_frame(2, 2, 1, 2, 3);
        run_frame(2, 2, 3, 1, 0);
        run_frame(2, 1, 1, 1, 2);
        run_frame(3, 1, 1, 1, 1);
        frame = 0;
        while (pixels_sent < 1650) begin
            case (frame % 14)
                3: run_frame(64, 2, 16, 1, 0);
                7: run_frame(2, 64, 1, 16, 4);
                11: run_frame(16, 16, 16, 16, $urandom_range(0, 4));
                default: begin
                    sh = $urandom_range(1, 9);
                    sw = $urandom_range(1, 9);
                    th = $urandom_range(1, 4);
                    tw = $urandom_range(1, 4);
                    run_frame(sh, sw, th, tw, ($urandom_range(0, 3) == 0) ?
                              $urandom_range(1, 4) : 0);
                end
            endcase
            frame++;
        end
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_ncc_template_match_core: clean");
        else
            $display("tb_ncc_template_match_core: errors");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("tb_ncc_template_match_core: errors");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/ncctm_pkg.sv
hw/rtl/ncctm_store.sv
hw/rtl/ncctm_mul.sv
hw/rtl/ncctm_seq.sv
hw/rtl/ncc_template_match_core.sv
hw/rtl/ncctm_checker.sv
tb/sv/tb_ncc_template_match_core_checker.sv
tb/sv/tb_ncc_template_match_core.sv
